// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the RTL. Each check is sampled on the rising
// clock edge and is not evaluated while the synchronous reset is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/core/brfg_pkg.sv =====
`timescale 1ns / 1ps
package brfg_pkg;

    localparam int NUM_CORES   = 8;
    localparam int WINDOW_SIZE = 32;
    localparam int CORE_W      = (NUM_CORES > 1) ? $clog2(NUM_CORES) : 1;
    localparam int PTR_W       = $clog2(WINDOW_SIZE);

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 40;

    localparam logic [CFG_IDX_W-1:0] CFG_RATIO_THR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDLE_THR  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_EN  = 2'd2;

    localparam logic [31:0] RATIO_THR_RST = 32'd6554;
    localparam logic [39:0] IDLE_THR_RST  = 40'd100000000;

    typedef enum logic [1:0] {
        ST_WRAP = 2'd0,
        ST_IDLE = 2'd1,
        ST_EVAL = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        CMD_NONE = 2'd0,
        CMD_MIN  = 2'd1,
        CMD_MAX  = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        FS_UNKNOWN = 2'd0,
        FS_MIN     = 2'd1,
        FS_MAX     = 2'd2
    } t_freq;

    typedef struct packed {
        logic [2:0]  core;
        logic [63:0] branch_count;
        logic [63:0] miss_count;
    } t_in;

    typedef struct packed {
        t_status     status;
        logic [31:0] ratio_q16;
        t_cmd        scale_command;
        t_freq       fstate;
    } t_out;

endpackage

// ===== rtl/core/branch_ratio_freq_governor_top.sv =====
`timescale 1ns / 1ps
// Channel   Direction  Handshake               Payload
// in        input      i_in_valid/o_in_ready   i_in_data (t_in)
// out       output     o_out_valid/i_out_ready o_out_data (t_out)
// cfg       input      i_cfg_valid/o_cfg_ready i_cfg_index, i_cfg_data
//
// A poll runs from its transfer to its registered result through six setup and
// compare steps on the shared 80-bit adder, 32 restoring divide steps on it, a
// vote step and an output step. A saturated ratio skips the divide; a skipped or
// idle poll goes straight to the output step. The input is ready only in the idle
// state, so no poll is taken before the last is through; a full output register
// stalls the output. Synchronous active-low reset clears the history and registers.
`include "assert_macros.svh"
module branch_ratio_freq_governor_top
    import brfg_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in                   i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out                  o_out_data,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int ALU_W = 80;

    typedef enum logic [3:0] {
        S_IDLE, S_BR, S_MS, S_IDL, S_M1, S_M2, S_SAT, S_DIV, S_VOTE, S_FIN
    } t_state;

    t_state r_state;

    logic [31:0] r_thr;
    logic [39:0] r_idle_thr;
    logic        r_scale_en;

    logic [63:0]            r_last_b [NUM_CORES];
    logic [63:0]            r_last_m [NUM_CORES];
    logic [WINDOW_SIZE-1:0] r_win    [NUM_CORES];
    logic [PTR_W-1:0]       r_ptr    [NUM_CORES];
    t_freq                  r_fs     [NUM_CORES];

    logic [CORE_W-1:0] r_core;
    logic [63:0]       r_nb, r_nm, r_lb, r_lm;
    logic [62:0]       r_hits, r_miss, r_rem;
    logic [69:0]       r_acc;
    logic [31:0]       r_quo, r_ratio;
    logic [4:0]        r_cnt;
    t_out              r_res, r_out;
    logic              r_out_valid;

    // Shared adder/subtractor.
    logic [ALU_W-1:0] alu_a, alu_b, alu_res;
    logic             alu_sub, alu_borrow, alu_zero;
    logic [ALU_W:0]   alu_sum;

    logic                   in_xfer, core_ok, v_up, q_bit;
    logic [WINDOW_SIZE-1:0] n_win;
    logic [PTR_W-1:0]       n_ptr;

    assign in_xfer     = i_in_valid && o_in_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign core_ok     = (32'(i_in_data.core) < NUM_CORES);

    always_comb begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b1;
        case (r_state)
            S_BR: begin
                alu_a = ALU_W'(r_nb[63:1]);
                alu_b = ALU_W'(r_lb[63:1]);
            end
            S_MS: begin
                alu_a = ALU_W'(r_nm[63:1]);
                alu_b = ALU_W'(r_lm[63:1]);
            end
            S_IDL: begin
                alu_a = ALU_W'(r_hits);
                alu_b = ALU_W'(r_idle_thr);
            end
            S_M1: begin
                alu_a   = ALU_W'({r_miss, 6'b0});
                alu_b   = ALU_W'({r_miss, 5'b0});
                alu_sub = 1'b0;
            end
            S_M2: begin
                alu_a   = ALU_W'(r_acc);
                alu_b   = ALU_W'({r_miss, 2'b0});
                alu_sub = 1'b0;
            end
            S_SAT: begin
                alu_a = ALU_W'(r_acc);
                alu_b = ALU_W'({r_hits, 16'b0});
            end
            S_DIV: begin
                alu_a = ALU_W'({r_rem, r_quo[31]});
                alu_b = ALU_W'(r_hits);
            end
            S_VOTE: begin
                alu_a = ALU_W'(r_thr);
                alu_b = ALU_W'(r_ratio);
            end
            default: begin
                alu_a = '0;
            end
        endcase
        alu_sum    = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)}
                     + (ALU_W+1)'(alu_sub);
        alu_res    = alu_sum[ALU_W-1:0];
        alu_borrow = alu_sub && !alu_sum[ALU_W];
        alu_zero   = (alu_res == '0);
    end

    // In the divide step a missing borrow gives a one quotient bit.
    assign q_bit = !alu_borrow;
    // The ratio is an up vote when it lies strictly above the threshold.
    assign v_up  = alu_borrow;

    always_comb begin
        n_win        = r_win[r_core];
        n_win[r_ptr[r_core]] = v_up;
        n_ptr = (r_ptr[r_core] == PTR_W'(WINDOW_SIZE - 1)) ? '0 : r_ptr[r_core] + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_thr       <= RATIO_THR_RST;
            r_idle_thr  <= IDLE_THR_RST;
            r_scale_en  <= 1'b1;
            for (int i = 0; i < NUM_CORES; i++) begin
                r_last_b[i] <= '0;
                r_last_m[i] <= '0;
                r_win[i]    <= '0;
                r_ptr[i]    <= '0;
                r_fs[i]     <= FS_UNKNOWN;
            end
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_RATIO_THR: r_thr      <= i_cfg_data[31:0];
                    CFG_IDLE_THR:  r_idle_thr <= i_cfg_data;
                    CFG_SCALE_EN:  r_scale_en <= i_cfg_data[0];
                    default:       r_thr      <= r_thr;
                endcase
            end

            // The output step handles its own valid flag.
            if (r_out_valid && i_out_ready && r_state != S_FIN) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        r_core <= i_in_data.core[CORE_W-1:0];
                        r_nb   <= i_in_data.branch_count;
                        r_nm   <= i_in_data.miss_count;
                        r_lb   <= r_last_b[i_in_data.core[CORE_W-1:0]];
                        r_lm   <= r_last_m[i_in_data.core[CORE_W-1:0]];
                        r_res  <= '{ST_WRAP, 32'd0, CMD_NONE, FS_UNKNOWN};
                        if (core_ok) begin
                            // The raw counts are kept even when the poll is skipped.
                            r_last_b[i_in_data.core[CORE_W-1:0]] <= i_in_data.branch_count;
                            r_last_m[i_in_data.core[CORE_W-1:0]] <= i_in_data.miss_count;
                            r_state <= S_BR;
                        end else begin
                            r_state <= S_FIN;
                        end
                    end
                end
                S_BR: begin
                    r_hits <= alu_res[62:0];
                    if (alu_borrow) begin
                        r_res.fstate <= r_fs[r_core];
                        r_state      <= S_FIN;
                    end else begin
                        r_state <= S_MS;
                    end
                end
                S_MS: begin
                    r_miss <= alu_res[62:0];
                    if (alu_borrow || alu_zero) begin
                        r_res.fstate <= r_fs[r_core];
                        r_state      <= S_FIN;
                    end else begin
                        r_state <= S_IDL;
                    end
                end
                S_IDL: begin
                    if (alu_borrow) begin
                        r_fs[r_core]        <= FS_MIN;
                        r_res.status        <= ST_IDLE;
                        r_res.scale_command <= r_scale_en ? CMD_MIN : CMD_NONE;
                        r_res.fstate        <= FS_MIN;
                        r_state             <= S_FIN;
                    end else begin
                        r_state <= S_M1;
                    end
                end
                S_M1: begin
                    r_acc   <= alu_res[69:0];
                    r_state <= S_M2;
                end
                S_M2: begin
                    r_acc   <= alu_res[69:0];
                    r_state <= S_SAT;
                end
                S_SAT: begin
                    // The quotient reaches 2^32 exactly when miss*100 >= hits*2^16.
                    if (!alu_borrow) begin
                        r_ratio <= '1;
                        r_state <= S_VOTE;
                    end else begin
                        r_rem   <= 63'(r_acc[69:16]);
                        r_quo   <= {r_acc[15:0], 16'b0};
                        r_cnt   <= '0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_rem <= q_bit ? alu_res[62:0] : {r_rem[61:0], r_quo[31]};
                    r_quo <= {r_quo[30:0], q_bit};
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == 5'd31) begin
                        r_ratio <= {r_quo[30:0], q_bit};
                        r_state <= S_VOTE;
                    end
                end
                S_VOTE: begin
                    r_win[r_core]   <= n_win;
                    r_ptr[r_core]   <= n_ptr;
                    r_res.status    <= ST_EVAL;
                    r_res.ratio_q16 <= r_ratio;
                    if (n_win == '0) begin
                        r_fs[r_core] <= FS_MIN;
                        r_res.fstate <= FS_MIN;
                        if (r_fs[r_core] != FS_MIN && r_scale_en) begin
                            r_res.scale_command <= CMD_MIN;
                        end
                    end else begin
                        r_fs[r_core] <= FS_MAX;
                        r_res.fstate <= FS_MAX;
                        if (r_fs[r_core] != FS_MAX && r_scale_en) begin
                            r_res.scale_command <= CMD_MAX;
                        end
                    end
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out       <= r_res;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    `ASSERT_NEXT(a_busy_after_xfer, i_clk, i_rst_n, in_xfer, !o_in_ready)
    `ASSERT_IMPL(a_rem_below_div, i_clk, i_rst_n, r_state == S_DIV, r_rem < r_hits)
    `ASSERT_IMPL(a_ratio_only_eval, i_clk, i_rst_n, o_out_valid && o_out_data.status != ST_EVAL, o_out_data.ratio_q16 == 32'd0)
    `ASSERT_IMPL(a_max_cmd_state, i_clk, i_rst_n, o_out_valid && o_out_data.scale_command == CMD_MAX, o_out_data.fstate == FS_MAX)

endmodule

// ===== tb/sv/branch_ratio_freq_governor_top_test.sv =====
`timescale 1ns / 1ps
module branch_ratio_freq_governor_top_test;
    import brfg_pkg::*;

    localparam logic [127:0] PCT_Q16_SCALE = 128'd6553600;
    localparam logic [63:0]  ALL_ONES_64   = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef enum logic {
        ROW_POLL,
        ROW_WRITE
    } t_row_kind;

    typedef struct {
        t_row_kind             kind;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] reg_val;
        t_in                   poll;
        bit                    typed;
        t_out                  want;
    } t_directed_row;

    typedef struct {
        logic [31:0] ratio_thr;
        logic [39:0] idle_thr;
        logic        enable;
        int          up_pct;
        int          idle_pct;
        int          core_hi;
        bit          draw_regs;
    } t_phase;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_ready;
    t_in                   i_in_data;
    logic                  o_out_valid;
    logic                  i_out_ready;
    t_out                  o_out_data;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    branch_ratio_freq_governor_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // Shadow of the governor's registers and per-core history.
    logic [31:0]            cur_ratio_thr;
    logic [39:0]            cur_idle_thr;
    logic                   cur_scale_en;
    logic [63:0]            prev_branches [NUM_CORES];
    logic [63:0]            prev_misses   [NUM_CORES];
    logic [WINDOW_SIZE-1:0] votes         [NUM_CORES];
    logic [PTR_W-1:0]       vote_slot     [NUM_CORES];
    t_freq                  core_state    [NUM_CORES];

    t_out          pending_results [$];
    t_directed_row directed_rows [$];
    t_phase        plan [$];
    t_out          result_want;
    int            mismatch_count = 0;
    int            results_seen = 0;
    bit            steady = 1'b0;

    function automatic t_out predict_governor_result(input t_in poll);
        t_out             res;
        logic [63:0]      b_now;
        logic [63:0]      b_prev;
        logic [63:0]      m_now;
        logic [63:0]      m_prev;
        logic [63:0]      hits;
        logic [63:0]      miss;
        logic [127:0]     quot;
        logic [PTR_W-1:0] slot;
        int               c;
        res = '0;
        c = int'(poll.core);
        if (c >= NUM_CORES) begin
            return res;
        end
        b_now  = poll.branch_count >> 1;
        b_prev = prev_branches[c] >> 1;
        m_now  = poll.miss_count >> 1;
        m_prev = prev_misses[c] >> 1;
        prev_branches[c] = poll.branch_count;
        prev_misses[c]   = poll.miss_count;
        if (b_now < b_prev || m_now <= m_prev) begin
            res.fstate = core_state[c];
            return res;
        end
        hits = b_now - b_prev;
        miss = m_now - m_prev;
        if (hits < {24'd0, cur_idle_thr}) begin
            core_state[c] = FS_MIN;
            res.status = ST_IDLE;
            if (cur_scale_en) begin
                res.scale_command = CMD_MIN;
            end
            res.fstate = FS_MIN;
            return res;
        end
        if (hits == 64'd0) begin
            res.ratio_q16 = '1;
        end else begin
            quot = ({64'd0, miss} * PCT_Q16_SCALE) / {64'd0, hits};
            res.ratio_q16 = (quot[127:32] != '0) ? 32'hFFFF_FFFF : quot[31:0];
        end
        slot = vote_slot[c];
        votes[c][slot] = (res.ratio_q16 > cur_ratio_thr);
        vote_slot[c] = (int'(slot) == WINDOW_SIZE - 1) ? '0 : slot + 1'b1;
        // The window only drives a command when the core's state actually changes.
        if (votes[c] == '0) begin
            if (core_state[c] != FS_MIN) begin
                core_state[c] = FS_MIN;
                if (cur_scale_en) begin
                    res.scale_command = CMD_MIN;
                end
            end
        end else if (core_state[c] != FS_MAX) begin
            core_state[c] = FS_MAX;
            if (cur_scale_en) begin
                res.scale_command = CMD_MAX;
            end
        end
        res.status = ST_EVAL;
        res.fstate = core_state[c];
        return res;
    endfunction

    // Builds the next poll from the stored counts, aiming the ratio at one side
    // of the threshold; a share of polls are idle, counter wraps or plain noise.
    function automatic t_in make_poll(input int up_pct, input int idle_pct, input int core_hi);
        t_in          p;
        logic [63:0]  hits_h;
        logic [63:0]  miss_h;
        logic [63:0]  jit;
        logic [127:0] at_thr;
        int           sel;
        int           c;
        p.core = 3'($urandom_range(0, core_hi));
        c = int'(p.core);
        sel = $urandom_range(0, 99);
        if (sel < 8) begin
            p.branch_count = {$urandom, $urandom};
            p.miss_count   = {$urandom, $urandom};
            return p;
        end
        if (sel < 12) begin
            if (sel[0]) begin
                p.branch_count = prev_branches[c] - 64'($urandom_range(2, 1000));
                p.miss_count   = prev_misses[c] + 64'($urandom_range(2, 1000));
            end else begin
                p.branch_count = prev_branches[c] + 64'($urandom_range(0, 100000));
                p.miss_count   = prev_misses[c] + 64'($urandom_range(0, 1));
            end
            return p;
        end
        if (sel < 12 + idle_pct) begin
            hits_h = (cur_idle_thr == '0) ? 64'd0 : {$urandom, $urandom} % {24'd0, cur_idle_thr};
            miss_h = 64'($urandom_range(1, 100000));
        end else begin
            hits_h = {24'd0, cur_idle_thr} + ({$urandom, $urandom} >> $urandom_range(30, 63));
            at_thr = ({64'd0, hits_h} * {96'd0, cur_ratio_thr}) / PCT_Q16_SCALE;
            if (at_thr[127:44] != '0) begin
                at_thr = 128'd1 << 44;
            end
            jit = ($urandom_range(0, 3) == 0) ? 64'($urandom_range(0, 1000)) : 64'd0;
            if ($urandom_range(0, 99) < up_pct) begin
                miss_h = at_thr[63:0] + 64'd1 + jit;
            end else begin
                miss_h = (at_thr[63:0] > jit) ? at_thr[63:0] - jit : 64'd1;
            end
            if (miss_h == 64'd0) begin
                miss_h = 64'd1;
            end
        end
        p.branch_count = prev_branches[c] + (hits_h << 1) + 64'($urandom_range(0, 1));
        p.miss_count   = prev_misses[c] + (miss_h << 1) + 64'($urandom_range(0, 1));
        return p;
    endfunction

    function automatic t_directed_row poll_row(input logic [2:0] core, input logic [63:0] b,
                                               input logic [63:0] m);
        t_directed_row row;
        row = '{kind: ROW_POLL, reg_idx: '0, reg_val: '0, poll: '0, typed: 1'b0, want: '0};
        row.poll = '{core: core, branch_count: b, miss_count: m};
        return row;
    endfunction

    function automatic t_directed_row typed_row(input logic [2:0] core, input logic [63:0] b,
                                                input logic [63:0] m, input t_status st,
                                                input logic [31:0] ratio, input t_cmd cmd,
                                                input t_freq fs);
        t_directed_row row;
        row = poll_row(core, b, m);
        row.typed = 1'b1;
        row.want = '{status: st, ratio_q16: ratio, scale_command: cmd, fstate: fs};
        return row;
    endfunction

    function automatic t_directed_row write_row(input logic [CFG_IDX_W-1:0] idx,
                                                input logic [CFG_DATA_W-1:0] value);
        t_directed_row row;
        row = '{kind: ROW_WRITE, reg_idx: idx, reg_val: value, poll: '0, typed: 1'b0,
                want: '0};
        return row;
    endfunction

    function automatic void add_row(input t_directed_row row);
        directed_rows = {directed_rows, row};
    endfunction

    function automatic void add_phase(input t_phase ph);
        plan = {plan, ph};
    endfunction

    task automatic check_field(input int idx, input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
                $display("result %0d: %s expected %0h, got %0h", idx, name, want, got);
            end
        end
    endtask

    // Lowers the poll valid and holds off until every expected result is back.
    task automatic wait_for_results();
        i_in_valid = 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        wait_for_results();
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = value;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_RATIO_THR: cur_ratio_thr = value[31:0];
            CFG_IDLE_THR:  cur_idle_thr = value[39:0];
            CFG_SCALE_EN:  cur_scale_en = value[0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic send_poll(input t_in poll, input bit typed, input t_out want);
        int   gap;
        t_out predicted;
        gap = steady ? 0 : $urandom_range(0, 15);
        if (gap != 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_in_data  = poll;
        do @(posedge i_clk); while (!o_in_ready);
        predicted = predict_governor_result(poll);
        pending_results = {pending_results, (typed ? want : predicted)};
        @(negedge i_clk);
    endtask

    initial begin : result_sink
        int stall;
        i_out_ready = 1'b0;
        forever begin
            stall = steady ? 0 : $urandom_range(0, 15);
            if (stall != 0) begin
                i_out_ready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_out_ready = 1'b1;
            do @(posedge i_clk); while (o_out_valid !== 1'b1);
            @(negedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display("result %0d: transfer with no result expected, got %0h",
                             results_seen, o_out_data);
                end
            end else begin
                result_want = pending_results.pop_front();
                check_field(results_seen, "status", 32'(result_want.status),
                            32'(o_out_data.status));
                check_field(results_seen, "ratio_q16", result_want.ratio_q16,
                            o_out_data.ratio_q16);
                check_field(results_seen, "scale_command", 32'(result_want.scale_command),
                            32'(o_out_data.scale_command));
                check_field(results_seen, "fstate", 32'(result_want.fstate),
                            32'(o_out_data.fstate));
            end
        end
    end

    initial begin : stimulus
        t_phase ph;
        t_out   no_want;
        no_want = '0;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        cur_ratio_thr = RATIO_THR_RST;
        cur_idle_thr  = IDLE_THR_RST;
        cur_scale_en  = 1'b1;
        for (int c = 0; c < NUM_CORES; c++) begin
            prev_branches[c] = '0;
            prev_misses[c]   = '0;
            votes[c]         = '0;
            vote_slot[c]     = '0;
            core_state[c]    = FS_UNKNOWN;
        end

        // Register writes in the table are applied only once the block has drained.
        add_row(typed_row(3'd0, 64'd0, 64'd0, ST_WRAP, 32'd0, CMD_NONE, FS_UNKNOWN));
        add_row(typed_row(3'd0, 64'd200000000, 64'd2, ST_EVAL, 32'd0, CMD_MIN, FS_MIN));
        add_row(typed_row(3'd0, 64'd200000002, 64'd2, ST_WRAP, 32'd0, CMD_NONE, FS_MIN));
        add_row(typed_row(3'd0, 64'd200000004, 64'd4, ST_IDLE, 32'd0, CMD_MIN, FS_MIN));
        add_row(typed_row(3'd1, ALL_ONES_64, ALL_ONES_64, ST_EVAL, 32'd6553600, CMD_MAX,
                          FS_MAX));
        add_row(typed_row(3'd1, 64'd0, ALL_ONES_64, ST_WRAP, 32'd0, CMD_NONE, FS_MAX));
        add_row(typed_row(3'd2, 64'd200000000, ALL_ONES_64, ST_EVAL, 32'hFFFF_FFFF,
                          CMD_MAX, FS_MAX));
        add_row(write_row(CFG_IDLE_THR, 40'd0));
        add_row(typed_row(3'd3, 64'd0, 64'd2, ST_EVAL, 32'hFFFF_FFFF, CMD_MAX, FS_MAX));
        add_row(write_row(CFG_SCALE_EN, 40'd0));
        add_row(typed_row(3'd4, 64'd1000, 64'd2, ST_EVAL, 32'd13107, CMD_NONE, FS_MAX));
        add_row(write_row(CFG_IDLE_THR, 40'hFF_FFFF_FFFF));
        add_row(typed_row(3'd4, 64'd1002, 64'd4, ST_IDLE, 32'd0, CMD_NONE, FS_MIN));
        add_row(write_row(CFG_SCALE_EN, 40'd1));
        add_row(write_row(CFG_IDLE_THR, 40'd0));
        add_row(write_row(CFG_RATIO_THR, 40'hFF_FFFF_FFFF));
        add_row(typed_row(3'd5, 64'd2, ALL_ONES_64, ST_EVAL, 32'hFFFF_FFFF, CMD_MIN,
                          FS_MIN));
        add_row(write_row(CFG_RATIO_THR, 40'd1));
        add_row(typed_row(3'd6, 64'd200, 64'd2, ST_EVAL, 32'd65536, CMD_MAX, FS_MAX));
        add_row(typed_row(3'd6, 64'd400, 64'd4, ST_EVAL, 32'd65536, CMD_NONE, FS_MAX));
        add_row(typed_row(3'd7, ALL_ONES_64, 64'd2, ST_EVAL, 32'd0, CMD_MIN, FS_MIN));
        add_row(write_row(CFG_RATIO_THR, 40'd65536));
        add_row(typed_row(3'd6, 64'd600, 64'd6, ST_EVAL, 32'd65536, CMD_NONE, FS_MAX));
        add_row(poll_row(3'd5, 64'h8000_0000_0000_0002, 64'h0000_0001_0000_0004));
        add_row(poll_row(3'd2, 64'h0123_4567_89AB_CDEF, 64'h0000_0000_00F0_0000));
        add_row(poll_row(3'd0, 64'd2000000000, 64'd10000000));

        // Each phase sets all three registers, then sends polls with its own vote mix.
        add_phase('{32'd6554, 40'd100000000, 1'b1, 30, 10, 7, 1'b0});
        add_phase('{32'd327680, 40'd1000, 1'b1, 5, 5, 1, 1'b0});
        add_phase('{32'd1, 40'd0, 1'b0, 20, 0, 7, 1'b0});
        add_phase('{32'hFFFF_FFFF, 40'hFF_FFFF_FFFF, 1'b1, 50, 10, 3, 1'b0});
        add_phase('{32'd6554, 40'd0, 1'b1, 3, 10, 0, 1'b1});
        add_phase('{32'd6554, 40'd100000000, 1'b0, 10, 10, 2, 1'b0});
        add_phase('{32'd65536, 40'd1, 1'b1, 60, 5, 7, 1'b0});
        add_phase('{32'd6554, 40'd0, 1'b1, 25, 10, 7, 1'b1});

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (directed_rows[r]) begin
            if (directed_rows[r].kind == ROW_WRITE) begin
                write_register(directed_rows[r].reg_idx, directed_rows[r].reg_val);
            end else begin
                send_poll(directed_rows[r].poll, directed_rows[r].typed, directed_rows[r].want);
            end
        end

        foreach (plan[p]) begin
            ph = plan[p];
            if (ph.draw_regs) begin
                ph.ratio_thr = $urandom_range(1, 2000000);
                ph.idle_thr  = 40'({$urandom, $urandom}) >> $urandom_range(0, 39);
                ph.enable    = 1'($urandom_range(0, 1));
            end
            write_register(CFG_RATIO_THR, {8'd0, ph.ratio_thr});
            write_register(CFG_IDLE_THR, ph.idle_thr);
            write_register(CFG_SCALE_EN, {39'd0, ph.enable});
            for (int n = 0; n < 212; n++) begin
                if (n % 40 == 0) begin
                    steady = ($urandom_range(0, 3) == 0);
                end
                if (n == 100) begin
                    wait_for_results();
                end
                send_poll(make_poll(ph.up_pct, ph.idle_pct, ph.core_hi), 1'b0, no_want);
            end
        end

        wait_for_results();
        repeat (50) @(posedge i_clk);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("PASS branch_ratio_freq_governor_top");
        end else begin
            $display("FAIL branch_ratio_freq_governor_top");
        end
        $finish;
    end

    initial begin : watchdog
        #20_000_000;
        $display("FAIL branch_ratio_freq_governor_top");
        $finish;
    end

endmodule
